/* rtl/lst_pkg.sv */
// shared types and constants of the lfsr scatter minimum tracker
package lst_pkg;

    localparam int MAX_ORDER_DEF  = 16;
    localparam int TIME_BITS_DEF  = 40;

    localparam int POS_BITS       = 16;
    localparam int OUT_BITS       = 40;
    localparam int ORDER_BITS     = 5;
    localparam int PASSES_BITS    = 8;
    localparam int BLOCK_BITS     = 25;
    localparam int CFG_DATA_BITS  = 25;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PROD_BITS      = POS_BITS + BLOCK_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PASSES = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK  = 2'd2;

    localparam logic [ORDER_BITS-1:0]  ORDER_MIN    = 5'd8;
    localparam logic [ORDER_BITS-1:0]  ORDER_RESET  = 5'd9;
    localparam logic [PASSES_BITS-1:0] PASSES_RESET = 8'd8;
    localparam logic [BLOCK_BITS-1:0]  BLOCK_RESET  = 25'd16384;
    localparam logic [BLOCK_BITS-1:0]  BLOCK_MAX    = 25'd16777216;
    localparam logic [POS_BITS-1:0]    LFSR_SEED    = 16'hace1;

    typedef struct packed {
        logic [ORDER_BITS-1:0]  order;
        logic [PASSES_BITS-1:0] passes;
        logic [BLOCK_BITS-1:0]  block_bytes;
    } cfg_t;

    typedef struct packed {
        logic [POS_BITS-1:0] here;
        logic [POS_BITS-1:0] nxt;
        logic                first_pass;
        logic                pass_end;
        logic                run_end;
    } walk_t;

endpackage

/* rtl/lfsr_scatter_min_tracker.sv */
// top level of the lfsr scatter minimum tracker
//
//  channel  direction  handshake            payload
//  in       into       in_valid / in_stall  time_ns
//  out      out of     out_valid/out_stall  position, best_time, next_offset, pass_end, run_end
//  cfg      into       cfg_we               cfg_index, cfg_data
//
// per item, the accept cycle reads the minimum table, then the compare state
// compares, writes back and loads the output register; no new item is taken until then
// the single table read port and the registered ram read set this split
// a stalled output holds the next item in its compare cycle until the register frees
// reset clears counters, state and out_valid; the table is not reset, the first pass fills it
module lfsr_scatter_min_tracker #(
    parameter int MAX_ORDER = lst_pkg::MAX_ORDER_DEF,
    parameter int TIME_BITS = lst_pkg::TIME_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [39:0]                        time_ns,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lst_pkg::POS_BITS-1:0]       position,
    output logic [lst_pkg::OUT_BITS-1:0]       best_time,
    output logic [lst_pkg::OUT_BITS-1:0]       next_offset,
    output logic                               pass_end,
    output logic                               run_end,
    input  logic                               cfg_we,
    input  logic [lst_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lst_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lst_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    cfg_t  cfg;
    walk_t walk;
    logic  restart;
    logic  accept;
    logic  commit;

    logic [63:0]          time_ext;
    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] rd_data;
    logic [TIME_BITS-1:0] new_min;
    logic [63:0]          min_ext;
    logic [PROD_BITS-1:0] prod;

    logic                out_valid_reg, out_valid_next;
    logic [POS_BITS-1:0] position_reg;
    logic [OUT_BITS-1:0] min_reg;
    logic [OUT_BITS-1:0] offset_reg;
    logic                pass_end_reg;
    logic                run_end_reg;

    lst_cfg #(
        .MAX_ORDER (MAX_ORDER)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    lst_walker #(
        .MAX_ORDER (MAX_ORDER)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .advance (commit),
        .walk    (walk)
    );

    lst_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (1 << MAX_ORDER)
    ) u_min_table (
        .clk   (clk),
        .we    (commit),
        .waddr (walk.here[MAX_ORDER-1:0]),
        .wdata (new_min),
        .re    (accept),
        .raddr (walk.here[MAX_ORDER-1:0]),
        .rdata (rd_data)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign commit   = (state_reg == ST_CALC) && (!out_valid_reg || !out_stall);

    assign time_ext = 64'(time_ns);
    assign new_min  = (walk.first_pass || (time_reg < rd_data)) ? time_reg : rd_data;
    assign min_ext  = 64'(new_min);
    assign prod     = PROD_BITS'(walk.nxt) * PROD_BITS'(cfg.block_bytes);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg <= time_ext[TIME_BITS-1:0];
        end
        if (commit)
        begin
            position_reg <= walk.here;
            min_reg      <= min_ext[OUT_BITS-1:0];
            offset_reg   <= prod[OUT_BITS-1:0];
            pass_end_reg <= walk.pass_end;
            run_end_reg  <= walk.run_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = position_reg;
    assign best_time   = min_reg;
    assign next_offset = offset_reg;
    assign pass_end    = pass_end_reg;
    assign run_end     = run_end_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CALC))
        else $error("accepted item did not enter compare cycle");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed item not presented");

    a_run_end_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && run_end_reg) |-> pass_end_reg)
        else $error("run end without pass end");

    a_pass_end_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pass_end_reg) |-> (offset_reg == '0))
        else $error("pass end with nonzero next offset");
`endif

endmodule

/* rtl/lst_ram.sv */
// generic single-port-write ram with registered read
module lst_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lst_cfg.sv */
// configuration registers with range saturation and run restart
module lst_cfg #(
    parameter int MAX_ORDER = lst_pkg::MAX_ORDER_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lst_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lst_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output lst_pkg::cfg_t                      cfg,
    output logic                               restart
);
    import lst_pkg::*;

    localparam logic [ORDER_BITS-1:0] ORDER_TOP  = ORDER_BITS'(MAX_ORDER);
    localparam logic [ORDER_BITS-1:0] ORDER_INIT =
        (ORDER_RESET > ORDER_TOP) ? ORDER_TOP : ORDER_RESET;

    logic [ORDER_BITS-1:0]  order_reg, order_next, order_sat;
    logic [PASSES_BITS-1:0] passes_reg, passes_next, passes_sat;
    logic [BLOCK_BITS-1:0]  block_reg, block_next, block_sat;

    always_comb
    begin
        order_sat = cfg_data[ORDER_BITS-1:0];
        if (order_sat < ORDER_MIN)
        begin
            order_sat = ORDER_MIN;
        end
        else if (order_sat > ORDER_TOP)
        begin
            order_sat = ORDER_TOP;
        end

        passes_sat = cfg_data[PASSES_BITS-1:0];
        if (passes_sat == '0)
        begin
            passes_sat = PASSES_BITS'(1);
        end

        block_sat = cfg_data[BLOCK_BITS-1:0];
        if (block_sat == '0)
        begin
            block_sat = BLOCK_BITS'(1);
        end
        else if (block_sat > BLOCK_MAX)
        begin
            block_sat = BLOCK_MAX;
        end
    end

    always_comb
    begin
        order_next  = order_reg;
        passes_next = passes_reg;
        block_next  = block_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORDER:
                begin
                    order_next = order_sat;
                    restart    = 1'b1;
                end
                REG_PASSES:
                begin
                    passes_next = passes_sat;
                    restart     = 1'b1;
                end
                REG_BLOCK:
                begin
                    block_next = block_sat;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= ORDER_INIT;
            passes_reg <= PASSES_RESET;
            block_reg  <= BLOCK_RESET;
        end
        else
        begin
            order_reg  <= order_next;
            passes_reg <= passes_next;
            block_reg  <= block_next;
        end
    end

    assign cfg.order       = order_reg;
    assign cfg.passes      = passes_reg;
    assign cfg.block_bytes = block_reg;

endmodule

/* rtl/lst_walker.sv */
// position sequencer: lfsr step, step and pass counters
module lst_walker #(
    parameter int MAX_ORDER = lst_pkg::MAX_ORDER_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lst_pkg::cfg_t  cfg,
    input  logic           restart,
    input  logic           advance,
    output lst_pkg::walk_t walk
);
    import lst_pkg::*;

    function automatic logic [POS_BITS-1:0] lfsr_next(
        input logic [POS_BITS-1:0]   v_in,
        input logic [ORDER_BITS-1:0] width
    );
        logic [POS_BITS:0]   mask_w;
        logic [POS_BITS-1:0] mask;
        logic [POS_BITS-1:0] v;
        logic [POS_BITS-1:0] fb;
        logic [POS_BITS-1:0] top;
        mask_w = ((POS_BITS+1)'(1) << width) - (POS_BITS+1)'(1);
        mask   = mask_w[POS_BITS-1:0];
        v      = v_in & mask;
        if (v == '0)
        begin
            v = LFSR_SEED & mask;
        end
        case (width)
            5'd8:    fb = v ^ (v >> 2) ^ (v >> 3) ^ (v >> 4);
            5'd9:    fb = v ^ (v >> 4);
            5'd10:   fb = v ^ (v >> 3);
            5'd11:   fb = v ^ (v >> 2);
            5'd12:   fb = v ^ (v >> 1) ^ (v >> 2) ^ (v >> 8);
            5'd13:   fb = v ^ (v >> 1) ^ (v >> 2) ^ (v >> 5);
            5'd14:   fb = v ^ (v >> 1) ^ (v >> 2) ^ (v >> 12);
            5'd15:   fb = v ^ (v >> 1);
            default: fb = v ^ (v >> 2) ^ (v >> 3) ^ (v >> 5);
        endcase
        top = POS_BITS'(fb[0]) << (width - ORDER_BITS'(1));
        return ((v >> 1) | top) & mask;
    endfunction

    logic [MAX_ORDER-1:0]   cur_pos_reg, cur_pos_next;
    logic [MAX_ORDER:0]     step_reg, step_next;
    logic [PASSES_BITS-1:0] pass_reg, pass_next;

    logic [MAX_ORDER:0]     span;
    logic [MAX_ORDER:0]     step_inc;
    logic [PASSES_BITS-1:0] pass_inc;
    logic [POS_BITS-1:0]    here16;
    logic [POS_BITS-1:0]    lfsr_pos;
    logic                   pend;
    logic                   rend;

    always_comb
    begin
        here16   = POS_BITS'(cur_pos_reg);
        lfsr_pos = lfsr_next(here16, cfg.order);
        span     = (MAX_ORDER+1)'(1) << cfg.order;
        step_inc = step_reg + (MAX_ORDER+1)'(1);
        pass_inc = pass_reg + PASSES_BITS'(1);
        pend     = (step_inc >= span);
        rend     = pend && (pass_inc >= cfg.passes);
    end

    assign walk.here       = here16;
    assign walk.nxt        = pend ? '0 : lfsr_pos;
    assign walk.first_pass = (pass_reg == '0);
    assign walk.pass_end   = pend;
    assign walk.run_end    = rend;

    always_comb
    begin
        cur_pos_next = cur_pos_reg;
        step_next    = step_reg;
        pass_next    = pass_reg;
        if (restart)
        begin
            cur_pos_next = '0;
            step_next    = '0;
            pass_next    = '0;
        end
        else if (advance)
        begin
            cur_pos_next = walk.nxt[MAX_ORDER-1:0];
            step_next    = pend ? '0 : step_inc;
            if (rend)
            begin
                pass_next = '0;
            end
            else if (pend)
            begin
                pass_next = pass_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg <= '0;
            step_reg    <= '0;
            pass_reg    <= '0;
        end
        else
        begin
            cur_pos_reg <= cur_pos_next;
            step_reg    <= step_next;
            pass_reg    <= pass_next;
        end
    end

endmodule
